/* src/mcs_pkg.sv */
// shared types and constants of the markov chain sampler
`timescale 1ns / 1ps
`default_nettype none

package mcs_pkg;

    // widths fixed by the item and register formats
    localparam int STATE_W   = 3;
    localparam int POS_W     = 16;
    localparam int NUM_W     = STATE_W + POS_W;
    localparam int RNG_W     = 64;
    localparam int PROBS_W   = 60;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_ROWS  = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_PROBS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED        = 3'd6;

    // reset values
    localparam logic [PROBS_W-1:0] PROBS_RESET = 60'h333333333333333;
    localparam logic [RNG_W-1:0]   SEED_RESET  = 64'd42;
    localparam logic [RNG_W-1:0]   ZERO_FIX    = 64'd42;

    // xorshift shift amounts
    localparam int XS_A = 12;
    localparam int XS_B = 25;
    localparam int XS_C = 27;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_SCAN,
        ST_POS,
        ST_MUL,
        ST_FIX
    } seq_state_t;

    // control of the random word unit
    typedef struct packed {
        logic load;
        logic step;
    } rng_ctrl_t;

endpackage

`default_nettype wire

/* src/mcs_if.sv */
// handshake channels of the markov chain sampler
`timescale 1ns / 1ps
`default_nettype none

interface mcs_req_if;
    logic valid;
    logic ready;
    logic start_new_chain;

    modport source (output valid, output start_new_chain, input ready);
    modport sink (input valid, input start_new_chain, output ready);
endinterface

interface mcs_sample_if;
    logic                       valid;
    logic                       ready;
    logic [mcs_pkg::STATE_W-1:0] chain_state;
    logic [mcs_pkg::POS_W-1:0]   position;

    modport source (output valid, output chain_state, output position, input ready);
    modport sink (input valid, input chain_state, input position, output ready);
endinterface

interface mcs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mcs_pkg::CFG_IDX_W-1:0] index;
    logic [mcs_pkg::RNG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/mcs_rng.sv */
// 64-bit xorshift word with seed load and zero fix
`timescale 1ns / 1ps
`default_nettype none

module mcs_rng (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mcs_pkg::rng_ctrl_t        ctrl,
    input  wire logic [mcs_pkg::RNG_W-1:0] seed,
    output logic [mcs_pkg::RNG_W-1:0]      word
);

    logic [mcs_pkg::RNG_W-1:0] word_reg;
    logic [mcs_pkg::RNG_W-1:0] word_next;
    logic [mcs_pkg::RNG_W-1:0] w0;
    logic [mcs_pkg::RNG_W-1:0] w1;
    logic [mcs_pkg::RNG_W-1:0] w2;
    logic [mcs_pkg::RNG_W-1:0] w3;

    // one xorshift step, a zero word restarts from the fixed value
    always_comb
    begin
        w0 = (word_reg == '0) ? mcs_pkg::ZERO_FIX : word_reg;
        w1 = w0 ^ (w0 >> mcs_pkg::XS_A);
        w2 = w1 ^ (w1 << mcs_pkg::XS_B);
        w3 = w2 ^ (w2 >> mcs_pkg::XS_C);
    end

    // seed load or step
    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            word_next = seed;
        end
        else if (ctrl.step)
        begin
            word_next = w3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= mcs_pkg::SEED_RESET;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

/* src/markov_chain_sampler_core.sv */
// markov chain sampler: sequencer, probability rows and position divider
// Usage:
//   sample_req carries one item per sample: start_new_chain picks the start
//   row, otherwise the row of the current chain state is used (the start row
//   is also used while no chain is active yet).
//   sample returns chain_state and position for every item, in order.
//   cfg writes register index 0 (start row), 1..5 (rows of states 0..4) or
//   6 (seed, reloads the random word); other indexes are dropped. Writes are
//   taken in every cycle and are meant for idle periods only.
// Sequence:
//   each item runs, in order, a random step, the running-sum compare over
//   the row entries at one row entry per cycle (stops at the first hit), a
//   second random step, a reciprocal multiply and a correction step. A new
//   item is taken only when idle again, after the previous one finishes.
// Reset:
//   rows reset to 819/4096 each, the word to 42, no chain active.
// Stall:
//   the result sits in an output register; while it is not taken a finished
//   sample waits in the correction cycle and the next item is held off.
`timescale 1ns / 1ps
`default_nettype none

module markov_chain_sampler_core #(
    parameter int CHAIN_STATES = 5,
    parameter int PROB_BITS    = 12
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mcs_req_if.sink     sample_req,
    mcs_sample_if.source sample,
    mcs_cfg_if.sink     cfg
);

    localparam int K_W         = $clog2(CHAIN_STATES);
    localparam int SUM_W       = PROB_BITS + $clog2(CHAIN_STATES);
    localparam int RECIP_SHIFT = 24;
    localparam int PROD_W      = mcs_pkg::NUM_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP = RECIP_SHIFT'((2 ** RECIP_SHIFT) / CHAIN_STATES);

    mcs_pkg::seq_state_t state_reg;
    mcs_pkg::seq_state_t state_next;

    logic [mcs_pkg::PROBS_W-1:0]   probs_reg [0:mcs_pkg::NUM_ROWS-1];
    logic [mcs_pkg::CFG_IDX_W-1:0] row_sel_reg;
    logic [K_W-1:0]                k_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [mcs_pkg::STATE_W-1:0]   pick_reg;
    logic [mcs_pkg::STATE_W-1:0]   cur_reg;
    logic                          active_reg;
    logic [mcs_pkg::NUM_W-1:0]     num_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic                          out_valid_reg;
    logic [mcs_pkg::STATE_W-1:0]   out_state_reg;
    logic [mcs_pkg::POS_W-1:0]     out_pos_reg;

    mcs_pkg::rng_ctrl_t        rng_ctrl;
    logic [mcs_pkg::RNG_W-1:0] rng_word;
    logic                      req_accept;
    logic                      cfg_accept;
    logic                      out_free;
    logic [mcs_pkg::PROBS_W-1:0] row_word;
    logic [SUM_W-1:0]          sum_new;
    logic                      hit;
    logic                      last_k;
    logic [mcs_pkg::POS_W-1:0] q_est;
    logic [mcs_pkg::NUM_W-1:0] rem;
    logic [mcs_pkg::POS_W-1:0] q_fix;

    // handshakes
    assign req_accept       = sample_req.valid && sample_req.ready;
    assign cfg_accept       = cfg.valid && cfg.ready;
    assign cfg.ready        = 1'b1;
    assign out_free         = !out_valid_reg || sample.ready;
    assign sample.valid       = out_valid_reg;
    assign sample.chain_state = out_state_reg;
    assign sample.position    = out_pos_reg;

    // random word unit
    mcs_rng u_rng (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (rng_ctrl),
        .seed  (cfg.data),
        .word  (rng_word)
    );

    // running-sum compare against the top bits of the word
    assign row_word = probs_reg[row_sel_reg];
    assign sum_new  = sum_reg + SUM_W'(row_word[k_reg * PROB_BITS +: PROB_BITS]);
    assign hit      = SUM_W'(rng_word[mcs_pkg::RNG_W-1 -: PROB_BITS]) < sum_new;
    assign last_k   = (k_reg == K_W'(CHAIN_STATES - 1));

    // reciprocal quotient with one correction step
    assign q_est = prod_reg[RECIP_SHIFT +: mcs_pkg::POS_W];
    assign rem   = num_reg - mcs_pkg::NUM_W'(q_est * CHAIN_STATES);
    assign q_fix = (rem >= mcs_pkg::NUM_W'(CHAIN_STATES)) ? q_est + 1'b1 : q_est;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mcs_pkg::ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = mcs_pkg::ST_DRAW;
                end
            end
            mcs_pkg::ST_DRAW:
            begin
                state_next = mcs_pkg::ST_SCAN;
            end
            mcs_pkg::ST_SCAN:
            begin
                if (hit || last_k)
                begin
                    state_next = mcs_pkg::ST_POS;
                end
            end
            mcs_pkg::ST_POS:
            begin
                state_next = mcs_pkg::ST_MUL;
            end
            mcs_pkg::ST_MUL:
            begin
                state_next = mcs_pkg::ST_FIX;
            end
            mcs_pkg::ST_FIX:
            begin
                if (out_free)
                begin
                    state_next = mcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcs_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample_req.ready = 1'b0;
        rng_ctrl.load    = cfg_accept && (cfg.index == mcs_pkg::REG_SEED);
        rng_ctrl.step    = 1'b0;
        unique case (state_reg)
            mcs_pkg::ST_IDLE: sample_req.ready = 1'b1;
            mcs_pkg::ST_DRAW: rng_ctrl.step = 1'b1;
            mcs_pkg::ST_POS:  rng_ctrl.step = 1'b1;
            default:          rng_ctrl.step = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // probability rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mcs_pkg::NUM_ROWS; i++)
            begin
                probs_reg[i] <= mcs_pkg::PROBS_RESET;
            end
        end
        else if (cfg_accept && (cfg.index < mcs_pkg::REG_SEED))
        begin
            probs_reg[cfg.index] <= cfg.data[mcs_pkg::PROBS_W-1:0];
        end
    end

    // chain state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == mcs_pkg::ST_FIX) && out_free)
            begin
                out_valid_reg <= 1'b1;
                cur_reg       <= pick_reg;
                active_reg    <= 1'b1;
            end
            else if (out_valid_reg && sample.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mcs_pkg::ST_IDLE:
            begin
                if (sample_req.start_new_chain || !active_reg)
                begin
                    row_sel_reg <= mcs_pkg::REG_START_PROBS;
                end
                else
                begin
                    row_sel_reg <= cur_reg + 1'b1;
                end
            end
            mcs_pkg::ST_DRAW:
            begin
                k_reg   <= '0;
                sum_reg <= '0;
            end
            mcs_pkg::ST_SCAN:
            begin
                sum_reg  <= sum_new;
                k_reg    <= k_reg + 1'b1;
                pick_reg <= mcs_pkg::STATE_W'(k_reg);
            end
            mcs_pkg::ST_MUL:
            begin
                num_reg  <= {pick_reg, rng_word[mcs_pkg::RNG_W-1 -: mcs_pkg::POS_W]};
                prod_reg <= PROD_W'({pick_reg, rng_word[mcs_pkg::RNG_W-1 -: mcs_pkg::POS_W]})
                            * PROD_W'(RECIP);
            end
            mcs_pkg::ST_FIX:
            begin
                if (out_free)
                begin
                    out_state_reg <= pick_reg;
                    out_pos_reg   <= q_fix;
                end
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    // an accepted item always starts with a random step
    assert property (@(posedge clk) disable iff (!rst_n)
        req_accept |=> state_reg == mcs_pkg::ST_DRAW)
        else $error("accepted item did not start a draw");

    // results only name existing states
    assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid |-> 32'(sample.chain_state) < CHAIN_STATES)
        else $error("chain state out of range");

    // the scan never walks past the last row entry
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mcs_pkg::ST_SCAN |-> 32'(k_reg) < CHAIN_STATES)
        else $error("scan index out of range");

    // a finished sample is only handed over when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !sample.ready) |=> $stable(out_pos_reg))
        else $error("stalled position changed");
`endif

endmodule

`default_nettype wire

/* bench/testbench.sv */
// self-checking bench of the markov chain sampler core with its own sample predictor
`timescale 1ns / 1ps

module testbench;

    localparam int N_STATES    = 5;
    localparam int P_BITS      = 12;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 200;
    localparam int LONG_HOLD   = 300;
    localparam logic [mcs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [mcs_pkg::STATE_W-1:0] chain_state;
        logic [mcs_pkg::POS_W-1:0]   position;
    } sample_t;

    // predicted chain, its registers and the samples still owed by the block
    class sample_predictor;
        logic [mcs_pkg::PROBS_W-1:0] probs [mcs_pkg::NUM_ROWS];
        logic [mcs_pkg::RNG_W-1:0]   word;
        logic [mcs_pkg::STATE_W-1:0] cur_state;
        bit                          active;
        sample_t                     expected_samples [$];
        int                          errors;

        function new();
            for (int i = 0; i < mcs_pkg::NUM_ROWS; i++)
            begin
                probs[i] = mcs_pkg::PROBS_RESET;
            end
            word      = mcs_pkg::SEED_RESET;
            cur_state = '0;
            active    = 1'b0;
            errors    = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch at %0t ns: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(input logic [mcs_pkg::CFG_IDX_W-1:0] idx,
                                input logic [mcs_pkg::RNG_W-1:0] data);
            if (idx == mcs_pkg::REG_SEED)
                word = data;
            else if (idx < mcs_pkg::REG_SEED)
                probs[idx] = data[mcs_pkg::PROBS_W-1:0];
        endfunction

        // xorshift step, a zero word is replaced first
        function logic [mcs_pkg::RNG_W-1:0] next_word();
            logic [mcs_pkg::RNG_W-1:0] w;
            w = (word == '0) ? mcs_pkg::ZERO_FIX : word;
            w = w ^ (w >> mcs_pkg::XS_A);
            w = w ^ (w << mcs_pkg::XS_B);
            w = w ^ (w >> mcs_pkg::XS_C);
            word = w;
            return w;
        endfunction

        // first entry whose running sum exceeds the drawn value, else the last state
        function logic [mcs_pkg::STATE_W-1:0] pick_state(
            input logic [mcs_pkg::PROBS_W-1:0] row);
            logic [mcs_pkg::RNG_W-1:0]   w;
            logic [P_BITS-1:0]           r;
            logic [P_BITS+2:0]           acc;
            logic [mcs_pkg::STATE_W-1:0] pick;
            bit                          hit;
            w    = next_word();
            r    = w[mcs_pkg::RNG_W-1 -: P_BITS];
            acc  = '0;
            hit  = 1'b0;
            pick = mcs_pkg::STATE_W'(N_STATES - 1);
            for (int k = 0; k < N_STATES; k++)
            begin
                if (!hit)
                begin
                    acc = acc + row[P_BITS*k +: P_BITS];
                    if (r < acc)
                    begin
                        hit  = 1'b1;
                        pick = mcs_pkg::STATE_W'(k);
                    end
                end
            end
            return pick;
        endfunction

        function void take_request(input logic start);
            logic [mcs_pkg::PROBS_W-1:0]                row;
            logic [mcs_pkg::RNG_W-1:0]                  w;
            logic [mcs_pkg::STATE_W+mcs_pkg::POS_W-1:0] num;
            sample_t                                    s;
            if (start || !active)
                row = probs[mcs_pkg::REG_START_PROBS];
            else
                row = probs[mcs_pkg::REG_START_PROBS + 1 + cur_state];
            s.chain_state = pick_state(row);
            w             = next_word();
            num           = {s.chain_state, w[mcs_pkg::RNG_W-1 -: mcs_pkg::POS_W]};
            s.position    = mcs_pkg::POS_W'(num / N_STATES);
            cur_state     = s.chain_state;
            active        = 1'b1;
            expected_samples.push_back(s);
        endfunction

        task check_sample(input sample_t got);
            sample_t want;
            if (expected_samples.size() == 0)
            begin
                report_mismatch($sformatf("sample state %0d position %0d with none expected",
                                          got.chain_state, got.position));
            end
            else
            begin
                want = expected_samples.pop_front();
                if (got.chain_state !== want.chain_state)
                    report_mismatch($sformatf("chain_state %0d, expected %0d",
                                              got.chain_state, want.chain_state));
                if (got.position !== want.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              got.position, want.position));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   hold_req;
    bit   no_idle;

    sample_predictor sb;

    mcs_req_if    req_ch ();
    mcs_sample_if smp_ch ();
    mcs_cfg_if    cfg_ch ();

    markov_chain_sampler_core #(
        .CHAIN_STATES (N_STATES),
        .PROB_BITS    (P_BITS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_req (req_ch.sink),
        .sample     (smp_ch.source),
        .cfg        (cfg_ch.sink)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // row with a single full entry
    function automatic logic [mcs_pkg::PROBS_W-1:0] one_hot(input int k);
        logic [mcs_pkg::PROBS_W-1:0] row;
        row = '0;
        row[P_BITS*k +: P_BITS] = '1;
        return row;
    endfunction

    function automatic logic [mcs_pkg::CFG_IDX_W-1:0] row_index(input int s);
        return mcs_pkg::REG_START_PROBS + mcs_pkg::CFG_IDX_W'(1 + s);
    endfunction

    // rows from empty to saturated, with shortfalls and near-even spreads
    function automatic logic [mcs_pkg::PROBS_W-1:0] random_row();
        logic [mcs_pkg::PROBS_W-1:0] row;
        row = '0;
        case ($urandom_range(0, 5))
            0: row = '0;
            1: row = {N_STATES{{P_BITS{1'b1}}}};
            2: row = mcs_pkg::PROBS_W'({$urandom, $urandom});
            3: row = one_hot($urandom_range(0, N_STATES - 1));
            4:
            begin
                for (int k = 0; k < N_STATES; k++)
                    row[P_BITS*k +: P_BITS] = P_BITS'($urandom_range(0, 1023));
            end
            default:
            begin
                for (int k = 0; k < N_STATES; k++)
                    row[P_BITS*k +: P_BITS] = P_BITS'($urandom_range(600, 1000));
            end
        endcase
        return row;
    endfunction

    function automatic logic [mcs_pkg::RNG_W-1:0] random_seed();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // config write, valid left high for a following write
    task automatic write_reg(input logic [mcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mcs_pkg::RNG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, data);
    endtask

    // one request item after a random gap, valid left high for the next
    task automatic send_item(input logic start);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.start_new_chain <= start;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.take_request(start);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (sb.expected_samples.size() != 0);
    endtask

    // result side: random stalls per item and the long hold when asked
    initial
    begin
        int wait_left;
        wait_left = 0;
        smp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && smp_ch.valid && smp_ch.ready)
            begin
                sb.check_sample('{chain_state: smp_ch.chain_state, position: smp_ch.position});
                wait_left = no_idle ? 0 : $urandom_range(0, 6);
            end
            if (hold_req > 0)
            begin
                wait_left = hold_req;
                hold_req  = 0;
            end
            if (wait_left > 0)
            begin
                smp_ch.ready <= 1'b0;
                wait_left--;
            end
            else
            begin
                smp_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin
        int pick_rate;
        sb       = new();
        hold_req = 0;
        no_idle  = 1'b0;
        rst_n                  <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.start_new_chain <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= '0;
        cfg_ch.data            <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // from reset: the start row is used until a chain is active
        send_item(1'b0);
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        send_item(1'b0);
        req_ch.valid <= 1'b0;
        drain();

        // empty start row falls to the last state, then a fixed loop 4 -> 1 -> 3 -> 4
        write_reg(mcs_pkg::REG_START_PROBS, '0);
        write_reg(row_index(0), {N_STATES{{P_BITS{1'b1}}}});
        write_reg(row_index(1), one_hot(3));
        write_reg(row_index(2), random_row());
        write_reg(row_index(3), '0);
        write_reg(row_index(4), one_hot(1));
        write_reg(mcs_pkg::REG_SEED, '0);
        write_reg(REG_UNUSED, '1);
        cfg_ch.valid <= 1'b0;
        send_item(1'b1);
        repeat (5) send_item(1'b0);
        req_ch.valid <= 1'b0;
        drain();

        // reseed in the middle of a chain, the chain state carries on
        write_reg(mcs_pkg::REG_SEED, '1);
        cfg_ch.valid <= 1'b0;
        repeat (3) send_item(1'b0);
        req_ch.valid <= 1'b0;
        drain();

        // saturated start row
        write_reg(mcs_pkg::REG_START_PROBS, {N_STATES{{P_BITS{1'b1}}}});
        cfg_ch.valid <= 1'b0;
        send_item(1'b1);
        req_ch.valid <= 1'b0;
        drain();

        // random phases, each with a fresh mix of rows and seed
        for (int ph = 0; ph < PHASES; ph++)
        begin
            no_idle   = (ph % 4 == 3);
            pick_rate = (ph % 2 == 1) ? 1 : 7;
            for (int i = 0; i <= REG_UNUSED; i++)
            begin
                if ($urandom_range(0, 1) == 1)
                    write_reg(mcs_pkg::CFG_IDX_W'(i),
                              (i == mcs_pkg::REG_SEED) ? random_seed()
                                                       : mcs_pkg::RNG_W'(random_row()));
            end
            cfg_ch.valid <= 1'b0;
            if (ph == 1)
                hold_req = LONG_HOLD;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender pause until every sample is back
                if (ph == 4 && n == PHASE_ITEMS / 2)
                begin
                    req_ch.valid <= 1'b0;
                    drain();
                end
                send_item($urandom_range(0, pick_rate) == 0);
            end
            req_ch.valid <= 1'b0;
            drain();
        end

        no_idle = 1'b0;
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("** markov_chain_sampler_core: PASSED **");
        else
            $display("** markov_chain_sampler_core: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("** markov_chain_sampler_core: FAILED **");
        $finish;
    end

endmodule
